// ----- src/mcpf_pkg.sv -----
package mcpf_pkg;

	// Packet limits and field widths
	localparam int unsigned PC_W      = 6;
	localparam int unsigned ROM_DEPTH = 47;
	localparam logic [4:0]  OP_LAST   = 5'd17;

	// Opcodes
	localparam logic [4:0] OP_DRIVE      = 5'd0;
	localparam logic [4:0] OP_FWD_BACK   = 5'd1;
	localparam logic [4:0] OP_TURN       = 5'd2;
	localparam logic [4:0] OP_RD_COUNT   = 5'd3;
	localparam logic [4:0] OP_RD_ENC_SPD = 5'd4;
	localparam logic [4:0] OP_RESET_ENC  = 5'd5;
	localparam logic [4:0] OP_PID        = 5'd6;
	localparam logic [4:0] OP_RD_SPEED   = 5'd7;
	localparam logic [4:0] OP_DUTY       = 5'd8;
	localparam logic [4:0] OP_DUTY_BOTH  = 5'd9;
	localparam logic [4:0] OP_SPEED      = 5'd10;
	localparam logic [4:0] OP_SPEED_BOTH = 5'd11;
	localparam logic [4:0] OP_SPEED_ACC  = 5'd12;
	localparam logic [4:0] OP_BOTH_ACC   = 5'd13;
	localparam logic [4:0] OP_PWM_RES    = 5'd14;
	localparam logic [4:0] OP_RD_MAIN_V  = 5'd15;
	localparam logic [4:0] OP_RD_LOGIC_V = 5'd16;
	localparam logic [4:0] OP_RD_VERSION = 5'd17;

	// PWM resolution limits
	localparam logic [7:0] PWM_MIN = 8'd8;
	localparam logic [7:0] PWM_MAX = 8'd14;
	localparam logic [7:0] SUM_MASK = 8'h7F;

	// Byte source of one microcode step
	typedef enum logic [2:0] {
		SRC_ADDR,
		SRC_CMD,
		SRC_MAG,
		SRC_PWM,
		SRC_SUM,
		SRC_WORD
	} src_t;

	// 32-bit operand selected by a word step
	typedef enum logic [2:0] {
		W_S1,
		W_S2,
		W_ACC,
		W_GP,
		W_GI,
		W_GD,
		W_PPS
	} wsel_t;

	// One control word
	typedef struct packed {
		src_t            src;
		wsel_t           wsel;
		logic [1:0]      bsel;   // 3 is the most significant byte
		logic            last;   // packet ends here
		logic            jump;   // go to target after this step
		logic            disp;   // dispatch on the opcode after this step
		logic [PC_W-1:0] target;
	} ctrl_t;

	// Dispatch entry of one opcode
	typedef struct packed {
		logic            ok;     // opcode emits a packet
		logic            rd;     // read request: address and command only
		logic [PC_W-1:0] entry;
	} disp_t;

	// Program addresses
	localparam logic [PC_W-1:0] PC_SUM     = 6'd2;
	localparam logic [PC_W-1:0] PC_MAG     = 6'd3;
	localparam logic [PC_W-1:0] PC_PWM     = 6'd4;
	localparam logic [PC_W-1:0] PC_DUTY    = 6'd5;
	localparam logic [PC_W-1:0] PC_DUTY2   = 6'd7;
	localparam logic [PC_W-1:0] PC_ACC_S12 = 6'd11;
	localparam logic [PC_W-1:0] PC_S12     = 6'd15;
	localparam logic [PC_W-1:0] PC_ACC_S1  = 6'd23;
	localparam logic [PC_W-1:0] PC_S1      = 6'd27;
	localparam logic [PC_W-1:0] PC_PID     = 6'd31;

	function automatic ctrl_t mk(src_t src, wsel_t wsel, logic [1:0] bsel,
			logic last, logic jump, logic [PC_W-1:0] target);
		ctrl_t c;
		c.src    = src;
		c.wsel   = wsel;
		c.bsel   = bsel;
		c.last   = last;
		c.jump   = jump;
		c.disp   = 1'b0;
		c.target = target;
		return c;
	endfunction

	// Data byte step, optionally jumping to the checksum
	function automatic ctrl_t wb(wsel_t wsel, logic [1:0] bsel, logic to_sum);
		return mk(SRC_WORD, wsel, bsel, 1'b0, to_sum, PC_SUM);
	endfunction

	// Microcode program
	function automatic ctrl_t rom(logic [PC_W-1:0] pc);
		ctrl_t c;
		c = mk(SRC_SUM, W_S1, 2'd0, 1'b1, 1'b0, PC_SUM);
		case (pc)
			6'd0:  c = mk(SRC_ADDR, W_S1, 2'd0, 1'b0, 1'b0, PC_SUM);
			6'd1:  begin
				c = mk(SRC_CMD, W_S1, 2'd0, 1'b0, 1'b0, PC_SUM);
				c.disp = 1'b1;
			end
			6'd2:  c = mk(SRC_SUM, W_S1, 2'd0, 1'b1, 1'b0, PC_SUM);
			6'd3:  c = mk(SRC_MAG, W_S1, 2'd0, 1'b0, 1'b1, PC_SUM);
			6'd4:  c = mk(SRC_PWM, W_S1, 2'd0, 1'b0, 1'b1, PC_SUM);
			// duty, one motor
			6'd5:  c = wb(W_S1, 2'd1, 1'b0);
			6'd6:  c = wb(W_S1, 2'd0, 1'b1);
			// duty, both motors
			6'd7:  c = wb(W_S1, 2'd1, 1'b0);
			6'd8:  c = wb(W_S1, 2'd0, 1'b0);
			6'd9:  c = wb(W_S2, 2'd1, 1'b0);
			6'd10: c = wb(W_S2, 2'd0, 1'b1);
			// both with accel falls into both speeds
			6'd11: c = wb(W_ACC, 2'd3, 1'b0);
			6'd12: c = wb(W_ACC, 2'd2, 1'b0);
			6'd13: c = wb(W_ACC, 2'd1, 1'b0);
			6'd14: c = wb(W_ACC, 2'd0, 1'b0);
			6'd15: c = wb(W_S1, 2'd3, 1'b0);
			6'd16: c = wb(W_S1, 2'd2, 1'b0);
			6'd17: c = wb(W_S1, 2'd1, 1'b0);
			6'd18: c = wb(W_S1, 2'd0, 1'b0);
			6'd19: c = wb(W_S2, 2'd3, 1'b0);
			6'd20: c = wb(W_S2, 2'd2, 1'b0);
			6'd21: c = wb(W_S2, 2'd1, 1'b0);
			6'd22: c = wb(W_S2, 2'd0, 1'b1);
			// speed with accel falls into single speed
			6'd23: c = wb(W_ACC, 2'd3, 1'b0);
			6'd24: c = wb(W_ACC, 2'd2, 1'b0);
			6'd25: c = wb(W_ACC, 2'd1, 1'b0);
			6'd26: c = wb(W_ACC, 2'd0, 1'b0);
			6'd27: c = wb(W_S1, 2'd3, 1'b0);
			6'd28: c = wb(W_S1, 2'd2, 1'b0);
			6'd29: c = wb(W_S1, 2'd1, 1'b0);
			6'd30: c = wb(W_S1, 2'd0, 1'b1);
			// PID: D, P, I, pulses per second
			6'd31: c = wb(W_GD, 2'd3, 1'b0);
			6'd32: c = wb(W_GD, 2'd2, 1'b0);
			6'd33: c = wb(W_GD, 2'd1, 1'b0);
			6'd34: c = wb(W_GD, 2'd0, 1'b0);
			6'd35: c = wb(W_GP, 2'd3, 1'b0);
			6'd36: c = wb(W_GP, 2'd2, 1'b0);
			6'd37: c = wb(W_GP, 2'd1, 1'b0);
			6'd38: c = wb(W_GP, 2'd0, 1'b0);
			6'd39: c = wb(W_GI, 2'd3, 1'b0);
			6'd40: c = wb(W_GI, 2'd2, 1'b0);
			6'd41: c = wb(W_GI, 2'd1, 1'b0);
			6'd42: c = wb(W_GI, 2'd0, 1'b0);
			6'd43: c = wb(W_PPS, 2'd3, 1'b0);
			6'd44: c = wb(W_PPS, 2'd2, 1'b0);
			6'd45: c = wb(W_PPS, 2'd1, 1'b0);
			6'd46: c = wb(W_PPS, 2'd0, 1'b1);
			default: c = mk(SRC_SUM, W_S1, 2'd0, 1'b1, 1'b0, PC_SUM);
		endcase
		return c;
	endfunction

	// Opcode dispatch table
	function automatic disp_t dispatch(logic [4:0] op);
		disp_t d;
		d.ok    = 1'b1;
		d.rd    = 1'b0;
		d.entry = PC_SUM;
		case (op)
			OP_DRIVE, OP_FWD_BACK, OP_TURN: d.entry = PC_MAG;
			OP_RD_COUNT, OP_RD_ENC_SPD, OP_RD_SPEED,
			OP_RD_MAIN_V, OP_RD_LOGIC_V, OP_RD_VERSION: d.rd = 1'b1;
			OP_RESET_ENC:  d.entry = PC_SUM;
			OP_PID:        d.entry = PC_PID;
			OP_DUTY:       d.entry = PC_DUTY;
			OP_DUTY_BOTH:  d.entry = PC_DUTY2;
			OP_SPEED:      d.entry = PC_S1;
			OP_SPEED_BOTH: d.entry = PC_S12;
			OP_SPEED_ACC:  d.entry = PC_ACC_S1;
			OP_BOTH_ACC:   d.entry = PC_ACC_S12;
			OP_PWM_RES:    d.entry = PC_PWM;
			default:       d.ok = 1'b0;
		endcase
		return d;
	endfunction

	// Command byte from opcode, motor and sign of the 8-bit speed
	function automatic logic [7:0] cmd_byte(logic [4:0] op, logic two, logic neg);
		logic [7:0] c;
		c = 8'd0;
		case (op)
			OP_DRIVE:      c = two ? (neg ? 8'd5 : 8'd4) : (neg ? 8'd1 : 8'd0);
			OP_FWD_BACK:   c = neg ? 8'd9 : 8'd8;
			OP_TURN:       c = neg ? 8'd10 : 8'd11;
			OP_RD_COUNT:   c = two ? 8'd17 : 8'd16;
			OP_RD_ENC_SPD: c = two ? 8'd19 : 8'd18;
			OP_RESET_ENC:  c = 8'd20;
			OP_PID:        c = two ? 8'd29 : 8'd28;
			OP_RD_SPEED:   c = two ? 8'd31 : 8'd30;
			OP_DUTY:       c = two ? 8'd33 : 8'd32;
			OP_DUTY_BOTH:  c = 8'd34;
			OP_SPEED:      c = two ? 8'd36 : 8'd35;
			OP_SPEED_BOTH: c = 8'd37;
			OP_SPEED_ACC:  c = two ? 8'd39 : 8'd38;
			OP_BOTH_ACC:   c = 8'd40;
			OP_PWM_RES:    c = 8'd48;
			OP_RD_MAIN_V:  c = 8'd24;
			OP_RD_LOGIC_V: c = 8'd25;
			OP_RD_VERSION: c = 8'd21;
			default:       c = 8'd0;
		endcase
		return c;
	endfunction

endpackage

// ----- src/motor_command_packet_framer_core.sv -----
// The first packet byte enters the output register after the sequencer enters ST_RUN.
// One packet byte per cycle while m_tready is high; a packet has 2 to 19 bytes,
// one per step of the microcode sequencer.
// A new command is taken once the last byte is in the output register.
// Reset (arst_n low, asynchronous) idles the sequencer, empties the output
// register and sets device_address to 0x80.
module motor_command_packet_framer_core (
	input  logic         clk,
	input  logic         arst_n,
	// input command beat
	input  logic         s_tvalid,
	output logic         s_tready,
	// [4:0] opcode, [5] motor_select, [37:6] speed_first, [69:38] speed_second,
	// [101:70] acceleration, [133:102] gain_p, [165:134] gain_i,
	// [197:166] gain_d, [229:198] pulses_per_second, [237:230] pwm_bits, rest zero
	input  logic [239:0] s_tdata,
	// output byte beat
	output logic         m_tvalid,
	input  logic         m_tready,
	// [7:0] tx_byte
	output logic [7:0]   m_tdata,
	output logic         m_tlast,
	// register port
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import mcpf_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t          state_q;
	logic [PC_W-1:0] pc_q;
	logic            rd_q;
	logic [PC_W-1:0] entry_q;
	logic [7:0]      addr_q;
	logic [7:0]      sum_q;
	logic [7:0]      cmd_q, mag_q, pwm_q;
	logic [31:0]     s1_q, s2_q, acc_q, gp_q, gi_q, gd_q, pps_q;
	logic            m_tvalid_q, m_tlast_q;
	logic [7:0]      m_tdata_q;

	logic            s_accept, run, load, step_last;
	logic [4:0]      in_op;
	logic [7:0]      in_lo8, in_pwm, pwm_clamp;
	disp_t           in_disp;
	ctrl_t           cw;
	logic [31:0]     word;
	logic [7:0]      byte_out;

	// Register port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {24'd0, addr_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= 8'h80;
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			addr_q <= pwdata[7:0];
		end
	end

	// Input decode
	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign in_op    = s_tdata[4:0];
	assign in_lo8   = s_tdata[13:6];
	assign in_pwm   = s_tdata[237:230];
	assign in_disp  = dispatch(in_op);

	always_comb begin
		pwm_clamp = in_pwm;
		if (in_pwm > PWM_MAX) pwm_clamp = PWM_MAX;
		if (in_pwm < PWM_MIN) pwm_clamp = PWM_MIN;
	end

	// Operand capture
	always_ff @(posedge clk) begin
		if (s_accept) begin
			cmd_q   <= cmd_byte(in_op, s_tdata[5], in_lo8[7]);
			mag_q   <= in_lo8[7] ? (8'd0 - in_lo8) : in_lo8;
			pwm_q   <= pwm_clamp - PWM_MIN;
			rd_q    <= in_disp.rd;
			entry_q <= in_disp.entry;
			s1_q    <= s_tdata[37:6];
			s2_q    <= s_tdata[69:38];
			acc_q   <= s_tdata[101:70];
			gp_q    <= s_tdata[133:102];
			gi_q    <= s_tdata[165:134];
			gd_q    <= s_tdata[197:166];
			pps_q   <= s_tdata[229:198];
		end
	end

	// Microcode fetch and byte datapath
	assign cw   = rom(pc_q);
	assign run  = (state_q == ST_RUN);
	assign load = run && (!m_tvalid_q || m_tready);
	assign step_last = cw.last || (cw.disp && rd_q);

	always_comb begin
		case (cw.wsel)
			W_S1:    word = s1_q;
			W_S2:    word = s2_q;
			W_ACC:   word = acc_q;
			W_GP:    word = gp_q;
			W_GI:    word = gi_q;
			W_GD:    word = gd_q;
			W_PPS:   word = pps_q;
			default: word = s1_q;
		endcase
	end

	always_comb begin
		case (cw.src)
			SRC_ADDR: byte_out = addr_q;
			SRC_CMD:  byte_out = cmd_q;
			SRC_MAG:  byte_out = mag_q;
			SRC_PWM:  byte_out = pwm_q;
			SRC_SUM:  byte_out = sum_q & SUM_MASK;
			SRC_WORD: byte_out = word[{cw.bsel, 3'b000} +: 8];
			default:  byte_out = 8'd0;
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q    <= '0;
			sum_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_accept && in_disp.ok) begin
						state_q <= ST_RUN;
						pc_q    <= '0;
						sum_q   <= '0;
					end
				end
				ST_RUN: begin
					if (load) begin
						sum_q <= sum_q + byte_out;
						if (step_last) begin
							state_q <= ST_IDLE;
						end else if (cw.disp) begin
							pc_q <= entry_q;
						end else if (cw.jump) begin
							pc_q <= cw.target;
						end else begin
							pc_q <= pc_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata_q <= byte_out;
			m_tlast_q <= step_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	// Checks
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		run |-> (pc_q < PC_W'(ROM_DEPTH)))
		else $error("microcode pc out of range");

	a_start_pc: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(run) |-> (pc_q == '0 && sum_q == 8'd0))
		else $error("packet did not start at address step");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(load && step_last) |=> (state_q == ST_IDLE && m_tvalid && m_tlast))
		else $error("sequencer did not finish on last byte");

	a_no_bad_start: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && in_op > OP_LAST) |=> (state_q == ST_IDLE))
		else $error("unused opcode started a packet");

endmodule

// ----- test/testbench.sv -----
module testbench;
	import mcpf_pkg::*;

	// Register map
	localparam logic [2:0] ADDR_DEVICE_ADDRESS = 3'd0;
	localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'h80;

	// Opcodes beyond the command set
	localparam logic [4:0] OP_UNUSED_LO = OP_LAST + 5'd1;
	localparam logic [4:0] OP_UNUSED_HI = 5'd31;

	// Command bytes on the serial link
	localparam logic [7:0] CMD_DRIVE_FWD_M1  = 8'd0;
	localparam logic [7:0] CMD_DRIVE_BACK_M1 = 8'd1;
	localparam logic [7:0] CMD_DRIVE_FWD_M2  = 8'd4;
	localparam logic [7:0] CMD_DRIVE_BACK_M2 = 8'd5;
	localparam logic [7:0] CMD_MIX_FWD       = 8'd8;
	localparam logic [7:0] CMD_MIX_BACK      = 8'd9;
	localparam logic [7:0] CMD_TURN_NEG      = 8'd10;
	localparam logic [7:0] CMD_TURN_POS      = 8'd11;
	localparam logic [7:0] CMD_RD_COUNT_M1   = 8'd16;
	localparam logic [7:0] CMD_RD_COUNT_M2   = 8'd17;
	localparam logic [7:0] CMD_RD_ENC_M1     = 8'd18;
	localparam logic [7:0] CMD_RD_ENC_M2     = 8'd19;
	localparam logic [7:0] CMD_RESET_ENC     = 8'd20;
	localparam logic [7:0] CMD_RD_VERSION    = 8'd21;
	localparam logic [7:0] CMD_RD_MAIN_V     = 8'd24;
	localparam logic [7:0] CMD_RD_LOGIC_V    = 8'd25;
	localparam logic [7:0] CMD_PID_M1        = 8'd28;
	localparam logic [7:0] CMD_PID_M2        = 8'd29;
	localparam logic [7:0] CMD_RD_SPEED_M1   = 8'd30;
	localparam logic [7:0] CMD_RD_SPEED_M2   = 8'd31;
	localparam logic [7:0] CMD_DUTY_M1       = 8'd32;
	localparam logic [7:0] CMD_DUTY_M2       = 8'd33;
	localparam logic [7:0] CMD_DUTY_BOTH     = 8'd34;
	localparam logic [7:0] CMD_SPEED_M1      = 8'd35;
	localparam logic [7:0] CMD_SPEED_M2      = 8'd36;
	localparam logic [7:0] CMD_SPEED_BOTH    = 8'd37;
	localparam logic [7:0] CMD_SPEED_ACC_M1  = 8'd38;
	localparam logic [7:0] CMD_SPEED_ACC_M2  = 8'd39;
	localparam logic [7:0] CMD_BOTH_ACC      = 8'd40;
	localparam logic [7:0] CMD_PWM_RES       = 8'd48;

	localparam int SETTLE_CYCLES = 25;
	localparam int LONG_HOLD     = 400;
	localparam int QUIET_LIMIT   = 2000;

	typedef struct {
		logic [4:0]  op;
		logic        two;
		logic [31:0] s1;
		logic [31:0] s2;
		logic [31:0] acc;
		logic [31:0] gp;
		logic [31:0] gi;
		logic [31:0] gd;
		logic [31:0] pps;
		logic [7:0]  pwm;
		bit          drain;	// wait for all bytes out before offering
	} motor_cmd_t;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} link_byte_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [239:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic m_tlast;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	motor_cmd_t pending_cmds[$];
	link_byte_t packet_bytes[$];
	motor_cmd_t offered;
	logic [7:0] device_addr = DEVICE_ADDRESS_RESET;
	bit tx_gaps_on = 1'b0;
	bit rx_stalls_on = 1'b0;
	int tx_gap = 0;
	int rx_hold = 0;
	int hold_asked = 0;
	int hold_taken = 0;
	int mismatches = 0;
	int bytes_seen = 0;
	int quiet_cycles = 0;

	motor_command_packet_framer_core u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #6 clk = ~clk;

	// Append one 32-bit value, most significant byte first
	function automatic void put_word(ref logic [7:0] pkt[$], input logic [31:0] w);
		pkt.push_back(w[31:24]);
		pkt.push_back(w[23:16]);
		pkt.push_back(w[15:8]);
		pkt.push_back(w[7:0]);
	endfunction

	// Build the serial packet of one command and queue its bytes
	function automatic void frame_command(motor_cmd_t c);
		logic [7:0] pkt[$];
		logic [7:0] mag;
		logic [7:0] cmd;
		logic [7:0] sum;
		logic [7:0] res;
		bit neg;
		bit with_sum;
		link_byte_t b;
		neg = c.s1[7];
		mag = neg ? 8'd0 - c.s1[7:0] : c.s1[7:0];
		with_sum = 1'b1;
		cmd = 8'd0;
		pkt.push_back(device_addr);
		pkt.push_back(8'd0);
		case (c.op)
			OP_DRIVE: begin
				if (c.two)
					cmd = neg ? CMD_DRIVE_BACK_M2 : CMD_DRIVE_FWD_M2;
				else
					cmd = neg ? CMD_DRIVE_BACK_M1 : CMD_DRIVE_FWD_M1;
				pkt.push_back(mag);
			end
			OP_FWD_BACK: begin
				cmd = neg ? CMD_MIX_BACK : CMD_MIX_FWD;
				pkt.push_back(mag);
			end
			OP_TURN: begin
				cmd = neg ? CMD_TURN_NEG : CMD_TURN_POS;
				pkt.push_back(mag);
			end
			OP_RD_COUNT: begin
				cmd = c.two ? CMD_RD_COUNT_M2 : CMD_RD_COUNT_M1;
				with_sum = 1'b0;
			end
			OP_RD_ENC_SPD: begin
				cmd = c.two ? CMD_RD_ENC_M2 : CMD_RD_ENC_M1;
				with_sum = 1'b0;
			end
			OP_RESET_ENC: cmd = CMD_RESET_ENC;
			OP_PID: begin
				cmd = c.two ? CMD_PID_M2 : CMD_PID_M1;
				put_word(pkt, c.gd);
				put_word(pkt, c.gp);
				put_word(pkt, c.gi);
				put_word(pkt, c.pps);
			end
			OP_RD_SPEED: begin
				cmd = c.two ? CMD_RD_SPEED_M2 : CMD_RD_SPEED_M1;
				with_sum = 1'b0;
			end
			OP_DUTY: begin
				cmd = c.two ? CMD_DUTY_M2 : CMD_DUTY_M1;
				pkt.push_back(c.s1[15:8]);
				pkt.push_back(c.s1[7:0]);
			end
			OP_DUTY_BOTH: begin
				cmd = CMD_DUTY_BOTH;
				pkt.push_back(c.s1[15:8]);
				pkt.push_back(c.s1[7:0]);
				pkt.push_back(c.s2[15:8]);
				pkt.push_back(c.s2[7:0]);
			end
			OP_SPEED: begin
				cmd = c.two ? CMD_SPEED_M2 : CMD_SPEED_M1;
				put_word(pkt, c.s1);
			end
			OP_SPEED_BOTH: begin
				cmd = CMD_SPEED_BOTH;
				put_word(pkt, c.s1);
				put_word(pkt, c.s2);
			end
			OP_SPEED_ACC: begin
				cmd = c.two ? CMD_SPEED_ACC_M2 : CMD_SPEED_ACC_M1;
				put_word(pkt, c.acc);
				put_word(pkt, c.s1);
			end
			OP_BOTH_ACC: begin
				cmd = CMD_BOTH_ACC;
				put_word(pkt, c.acc);
				put_word(pkt, c.s1);
				put_word(pkt, c.s2);
			end
			OP_PWM_RES: begin
				cmd = CMD_PWM_RES;
				res = c.pwm;
				if (res > PWM_MAX) res = PWM_MAX;
				if (res < PWM_MIN) res = PWM_MIN;
				pkt.push_back(res - PWM_MIN);
			end
			OP_RD_MAIN_V: begin
				cmd = CMD_RD_MAIN_V;
				with_sum = 1'b0;
			end
			OP_RD_LOGIC_V: begin
				cmd = CMD_RD_LOGIC_V;
				with_sum = 1'b0;
			end
			OP_RD_VERSION: begin
				cmd = CMD_RD_VERSION;
				with_sum = 1'b0;
			end
			// unused opcodes send nothing
			default: return;
		endcase
		pkt[1] = cmd;
		if (with_sum) begin
			sum = 8'd0;
			foreach (pkt[k])
				sum += pkt[k];
			pkt.push_back(sum & SUM_MASK);
		end
		foreach (pkt[k]) begin
			b.data = pkt[k];
			b.last = (k == pkt.size() - 1);
			packet_bytes.push_back(b);
		end
	endfunction

	// Idle length: mostly none or short, now and then long
	function automatic int pick_idle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Word with a bias toward the sign and range corners
	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return ($urandom & 32'hFFFF_FF00) | 32'h0000_0080;
			5: return ($urandom & 32'hFFFF_0000) | 32'h0000_8000;
			default: return $urandom;
		endcase
	endfunction

	function automatic motor_cmd_t make_cmd(logic [4:0] op, logic two, logic [31:0] s1,
			logic [31:0] s2, logic [31:0] wide, logic [7:0] pwm);
		motor_cmd_t c;
		c.op = op;
		c.two = two;
		c.s1 = s1;
		c.s2 = s2;
		c.acc = wide;
		c.gp = wide;
		c.gi = wide;
		c.gd = wide;
		c.pps = wide;
		c.pwm = pwm;
		c.drain = 1'b0;
		return c;
	endfunction

	function automatic motor_cmd_t random_cmd();
		motor_cmd_t c;
		if ($urandom_range(0, 19) == 0)
			c.op = 5'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
		else
			c.op = 5'($urandom_range(OP_DRIVE, OP_LAST));
		c.two = 1'($urandom_range(0, 1));
		c.s1 = pick_word();
		c.s2 = pick_word();
		c.acc = pick_word();
		c.gp = pick_word();
		c.gi = pick_word();
		c.gd = pick_word();
		c.pps = pick_word();
		c.pwm = $urandom_range(0, 1) ? 8'($urandom_range(6, 16)) : 8'($urandom);
		c.drain = 1'b0;
		return c;
	endfunction

	// Register write: setup beat then access beat
	task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_DEVICE_ADDRESS)
			device_addr = value[7:0];
	endtask

	// Wait until every command is taken and every byte is out
	task automatic wait_drained();
		while (pending_cmds.size() != 0 || s_tvalid || packet_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic queue_random(input int count, input int drain_at);
		motor_cmd_t c;
		for (int i = 0; i < count; i++) begin
			c = random_cmd();
			c.drain = (i == drain_at);
			pending_cmds.push_back(c);
		end
	endtask

	// Command sender
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				frame_command(offered);
			if (!s_tvalid || s_tready) begin
				if (tx_gap != 0) begin
					tx_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_cmds.size() != 0 &&
						!(pending_cmds[0].drain && packet_bytes.size() != 0)) begin
					offered = pending_cmds.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {2'b00, offered.pwm, offered.pps, offered.gd, offered.gi,
						offered.gp, offered.acc, offered.s2, offered.s1, offered.two,
						offered.op};
					tx_gap = tx_gaps_on ? pick_idle() : 0;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Byte receiver and checker
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (packet_bytes.size() == 0) begin
					if (mismatches < 10)
						$display("beat %0d: unexpected byte %02h last %0b",
							bytes_seen, m_tdata, m_tlast);
					mismatches++;
				end else if (m_tdata !== packet_bytes[0].data ||
						m_tlast !== packet_bytes[0].last) begin
					if (mismatches < 10)
						$display("beat %0d: expected %02h last %0b, got %02h last %0b",
							bytes_seen, packet_bytes[0].data, packet_bytes[0].last,
							m_tdata, m_tlast);
					mismatches++;
				end
				if (packet_bytes.size() != 0)
					void'(packet_bytes.pop_front());
				bytes_seen++;
			end
			if (hold_asked != hold_taken) begin
				hold_taken++;
				rx_hold = LONG_HOLD;
			end else if (rx_hold == 0 && rx_stalls_on && m_tready) begin
				rx_hold = pick_idle();
			end
			if (rx_hold != 0) begin
				rx_hold--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == QUIET_LIMIT) begin
				$display("simulation failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		motor_cmd_t c;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed commands at the reset address, random idling
		tx_gaps_on = 1'b1;
		rx_stalls_on = 1'b1;
		pending_cmds.push_back(make_cmd(OP_DRIVE, 1'b0, 32'h0000_0000, 32'h0, 32'h0, 8'd0));
		pending_cmds.push_back(make_cmd(OP_DRIVE, 1'b1, 32'hFFFF_FF80, 32'h0, 32'h0, 8'd0));
		pending_cmds.push_back(make_cmd(OP_DRIVE, 1'b0, 32'h0000_007F, 32'h0, 32'h0, 8'd0));
		pending_cmds.push_back(make_cmd(OP_DRIVE, 1'b1, 32'h1234_5601, 32'h0, 32'h0, 8'd0));
		pending_cmds.push_back(make_cmd(OP_FWD_BACK, 1'b0, 32'hFFFF_FFFF, 32'h0, 32'h0, 8'd0));
		pending_cmds.push_back(make_cmd(OP_TURN, 1'b1, 32'h0000_0080, 32'h0, 32'h0, 8'd0));
		pending_cmds.push_back(make_cmd(OP_TURN, 1'b0, 32'h0000_0001, 32'h0, 32'h0, 8'd0));
		pending_cmds.push_back(make_cmd(OP_RD_COUNT, 1'b1, 32'h0, 32'h0, 32'h0, 8'd0));
		pending_cmds.push_back(make_cmd(OP_RD_ENC_SPD, 1'b0, 32'h0, 32'h0, 32'h0, 8'd0));
		pending_cmds.push_back(make_cmd(OP_RESET_ENC, 1'b1, 32'h0, 32'h0, 32'h0, 8'd0));
		c = make_cmd(OP_PID, 1'b0, 32'h0, 32'h0, 32'h0, 8'd0);
		c.gp = 32'h1122_3344;
		c.gi = 32'h5566_7788;
		c.gd = 32'h99AA_BBCC;
		c.pps = 32'hDDEE_FF01;
		pending_cmds.push_back(c);
		pending_cmds.push_back(make_cmd(OP_PID, 1'b1, 32'h0, 32'h0, 32'hFFFF_FFFF, 8'd0));
		pending_cmds.push_back(make_cmd(OP_RD_SPEED, 1'b1, 32'h0, 32'h0, 32'h0, 8'd0));
		pending_cmds.push_back(make_cmd(OP_DUTY, 1'b1, 32'h0000_8000, 32'h0, 32'h0, 8'd0));
		pending_cmds.push_back(make_cmd(OP_DUTY_BOTH, 1'b0, 32'hABCD_7FFF, 32'hFFFF_8000,
			32'h0, 8'd0));
		pending_cmds.push_back(make_cmd(OP_SPEED, 1'b0, 32'h8000_0000, 32'h0, 32'h0, 8'd0));
		pending_cmds.push_back(make_cmd(OP_SPEED_BOTH, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h0, 8'd0));
		pending_cmds.push_back(make_cmd(OP_SPEED_ACC, 1'b1, 32'hFFFF_FFFF, 32'h0,
			32'hFFFF_FFFF, 8'd0));
		pending_cmds.push_back(make_cmd(OP_BOTH_ACC, 1'b0, 32'h0000_0001, 32'hFFFF_FFFE,
			32'h0001_0000, 8'd0));
		// PWM resolution below, inside and above the clamp range
		pending_cmds.push_back(make_cmd(OP_PWM_RES, 1'b0, 32'h0, 32'h0, 32'h0, 8'd0));
		pending_cmds.push_back(make_cmd(OP_PWM_RES, 1'b1, 32'h0, 32'h0, 32'h0, 8'd11));
		pending_cmds.push_back(make_cmd(OP_PWM_RES, 1'b0, 32'h0, 32'h0, 32'h0, 8'd255));
		pending_cmds.push_back(make_cmd(OP_RD_MAIN_V, 1'b0, 32'h0, 32'h0, 32'h0, 8'd0));
		pending_cmds.push_back(make_cmd(OP_RD_LOGIC_V, 1'b1, 32'h0, 32'h0, 32'h0, 8'd0));
		pending_cmds.push_back(make_cmd(OP_RD_VERSION, 1'b0, 32'h0, 32'h0, 32'h0, 8'd0));
		pending_cmds.push_back(make_cmd(OP_UNUSED_LO, 1'b0, 32'h0, 32'h0, 32'h0, 8'd0));
		pending_cmds.push_back(make_cmd(OP_UNUSED_HI, 1'b1, 32'h0, 32'h0, 32'h0, 8'd0));
		wait_drained();

		// Top address, back-to-back commands into a long receiver hold
		write_reg(ADDR_DEVICE_ADDRESS, 32'h0000_00FF);
		tx_gaps_on = 1'b0;
		rx_stalls_on = 1'b0;
		hold_asked++;
		queue_random(25, -1);
		wait_drained();

		// Zero address, idling on both sides, one pause for a full drain
		write_reg(ADDR_DEVICE_ADDRESS, 32'h0000_0000);
		tx_gaps_on = 1'b1;
		rx_stalls_on = 1'b1;
		queue_random(25, 12);
		wait_drained();

		// Random address, receiver stalls only
		write_reg(ADDR_DEVICE_ADDRESS, $urandom);
		tx_gaps_on = 1'b0;
		queue_random(25, -1);
		wait_drained();

		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ----- motor_command_packet_framer_core.f -----
src/mcpf_pkg.sv
src/motor_command_packet_framer_core.sv
test/testbench.sv
